@@ rtl/pscd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_pkg
// Shared types and constants of the paired stack dependency check.
// ----------------------------------------------------------------------------
package pscd_pkg;

    localparam int COLOR_W  = 11;
    localparam int CFG_W    = 11;
    localparam int REASON_W = 3;
    localparam int PAIR     = 2;

    localparam logic [REASON_W-1:0] FAIL_NONE  = 3'd0;
    localparam logic [REASON_W-1:0] FAIL_COUNT = 3'd1;
    localparam logic [REASON_W-1:0] FAIL_SAME  = 3'd2;
    localparam logic [REASON_W-1:0] FAIL_CYCLE = 3'd3;
    localparam logic [REASON_W-1:0] FAIL_OVER  = 3'd4;

    typedef enum logic [3:0] {
        E_CLEAR,
        E_IDLE,
        E_LOAD,
        E_SCAN,
        E_QRD,
        E_ARD,
        E_SLOT,
        E_BRD,
        E_BWB,
        E_RES
    } t_eng_state;

    typedef struct packed {
        logic                ready;
        logic                res_valid;
        logic [REASON_W-1:0] res_reason;
    } t_eng_status;

endpackage

@@ rtl/pscd_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_if
// Valid/ready channels for loaded items and for check results.
// ----------------------------------------------------------------------------
interface pscd_item_if;
    logic        valid;
    logic        ready;
    logic [10:0] color;
    logic        new_stack;
    logic        last;

    modport source (output valid, output color, output new_stack, output last, input ready);
    modport sink   (input valid, input color, input new_stack, input last, output ready);
endinterface

interface pscd_result_if;
    logic       valid;
    logic       ready;
    logic       can_clear;
    logic [2:0] fail_reason;

    modport source (output valid, output can_clear, output fail_reason, input ready);
    modport sink   (input valid, input can_clear, input fail_reason, output ready);
endinterface

@@ rtl/pscd_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pscd_engine
// Per-color tables in block memories, item load, final scan, Kahn walk and
// the clearing sweep.
// ----------------------------------------------------------------------------
module pscd_engine #(
    parameter int MAX_COLORS = 1024,
    parameter int MAX_STACKS = 1024
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_item_valid,
    input  logic [10:0]            i_color,
    input  logic                   i_new_stack,
    input  logic                   i_last,
    input  logic [10:0]            i_num_colors,
    input  logic                   i_res_free,
    output pscd_pkg::t_eng_status  o_status
);
    import pscd_pkg::*;

    localparam int CW  = $clog2(MAX_COLORS);
    localparam int KW  = CW + 1;
    localparam int SW  = $clog2(MAX_STACKS);
    localparam int SCW = SW + 1;
    localparam logic [KW-1:0] K_END  = KW'(MAX_COLORS);
    localparam logic [KW-1:0] K_LAST = KW'(MAX_COLORS - 1);

    typedef struct packed {
        logic [1:0]    occ;
        logic [SW-1:0] first;
        logic          shares;
        logic [1:0]    scnt;
        logic [CW-1:0] slot1;
        logic [CW-1:0] slot0;
    } t_aent;

    // memories
    t_aent         r_a_mem [MAX_COLORS];
    logic [1:0]    r_b_mem [MAX_COLORS];
    logic [CW-1:0] r_q_mem [MAX_COLORS];
    t_aent         r_a_rdata;
    logic [1:0]    r_b_rdata;
    logic [CW-1:0] r_q_rdata;

    logic          a_re, a_we, b_re, b_we, q_re, q_we;
    logic [CW-1:0] a_raddr, a_waddr, b_raddr, b_waddr, q_raddr, q_waddr, q_wdata;
    t_aent         a_wdata;
    logic [1:0]    b_wdata;

    t_eng_state    r_state, n_state;

    logic [KW-1:0]       r_k, r_head, r_tail, r_visited;
    logic                r_pv;
    logic [CW-1:0]       r_pk;
    logic                r_fail;
    logic [REASON_W-1:0] r_fail_reason;
    logic [10:0]         r_prev;
    logic [SCW-1:0]      r_stack_cnt;
    logic                r_over, r_bad;
    logic [CW-1:0]       r_ci, r_pi;
    logic                r_hp, r_cok, r_last;
    logic [SW-1:0]       r_sidx;
    logic [1:0]          r_scnt, r_s;
    logic [CW-1:0]       r_slot0, r_slot1;
    logic [CW-1:0]       r_nb;

    // item acceptance
    logic           acc_start, acc_over, acc_cok;
    logic [SCW-1:0] acc_cnt;
    logic [10:0]    acc_prev;
    logic [CW-1:0]  acc_ci, acc_pi;

    always_comb begin
        acc_start = i_new_stack || (r_stack_cnt == '0);
        acc_over  = acc_start && (32'(r_stack_cnt) >= MAX_STACKS);
        acc_cnt   = (acc_start && !acc_over) ? r_stack_cnt + 1'b1 : r_stack_cnt;
        acc_prev  = acc_start ? 11'd0 : r_prev;
        acc_cok   = (i_color != 11'd0) && (i_color <= i_num_colors)
                    && (32'(i_color) <= MAX_COLORS);
        acc_ci    = CW'(32'(i_color) - 1);
        acc_pi    = CW'(32'(acc_prev) - 1);
    end

    // load update of a color entry
    t_aent ld_a;
    always_comb begin
        ld_a = r_a_rdata;
        if (r_a_rdata.occ == 2'd0) begin
            ld_a.first = r_sidx;
        end else if (r_a_rdata.occ == 2'd1 && r_a_rdata.first == r_sidx) begin
            ld_a.shares = 1'b1;
        end
        if (r_a_rdata.occ != 2'd3) ld_a.occ = r_a_rdata.occ + 2'd1;
        if (r_hp && r_a_rdata.scnt < 2'd2) begin
            if (r_a_rdata.scnt == 2'd0) ld_a.slot0 = r_pi;
            else ld_a.slot1 = r_pi;
            ld_a.scnt = r_a_rdata.scnt + 2'd1;
        end
    end

    // scan checks
    logic                scan_in, scan_bad, scan_push, scan_done, scan_stop, nc_big;
    logic [REASON_W-1:0] scan_reason;
    logic [REASON_W-1:0] res_reason;
    always_comb begin
        scan_in     = 32'(r_pk) < 32'(i_num_colors);
        scan_bad    = 1'b0;
        scan_reason = FAIL_COUNT;
        if (scan_in) begin
            if (r_a_rdata.occ != 2'(PAIR)) begin
                scan_bad = 1'b1;
            end else if (r_a_rdata.shares) begin
                scan_bad    = 1'b1;
                scan_reason = FAIL_SAME;
            end
        end else if (r_a_rdata.occ != 2'd0) begin
            scan_bad = 1'b1;
        end
        scan_push = r_pv && scan_in && (r_b_rdata == 2'd0);
        scan_done = (r_k == K_END) && !r_pv;
        nc_big    = 32'(i_num_colors) > MAX_COLORS;
        scan_stop = r_over || r_bad || nc_big || r_fail;
        if (r_over) res_reason = FAIL_OVER;
        else if (r_bad || nc_big) res_reason = FAIL_COUNT;
        else if (r_fail) res_reason = r_fail_reason;
        else if (32'(r_visited) == 32'(i_num_colors)) res_reason = FAIL_NONE;
        else res_reason = FAIL_CYCLE;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            E_IDLE:  if (i_item_valid) n_state = E_LOAD;
            E_LOAD:  n_state = r_last ? E_SCAN : E_IDLE;
            E_SCAN:  if (scan_done) n_state = scan_stop ? E_RES : E_QRD;
            E_QRD:   n_state = (r_head == r_tail) ? E_RES : E_ARD;
            E_ARD:   n_state = E_SLOT;
            E_SLOT:  n_state = E_BRD;
            E_BRD:   n_state = (r_s < r_scnt) ? E_BWB : E_QRD;
            E_BWB:   n_state = E_BRD;
            E_RES:   if (i_res_free) n_state = E_CLEAR;
            E_CLEAR: if (r_k == K_LAST) n_state = E_IDLE;
            default: n_state = E_CLEAR;
        endcase
    end

    // memory controls and status
    always_comb begin
        a_re = 1'b0; a_raddr = '0; a_we = 1'b0; a_waddr = '0; a_wdata = '0;
        b_re = 1'b0; b_raddr = '0; b_we = 1'b0; b_waddr = '0; b_wdata = '0;
        q_re = 1'b0; q_raddr = '0; q_we = 1'b0; q_waddr = '0; q_wdata = '0;
        o_status = '0;
        case (r_state)
            E_IDLE: begin
                o_status.ready = 1'b1;
                a_re    = i_item_valid;
                a_raddr = acc_ci;
                b_re    = i_item_valid;
                b_raddr = acc_pi;
            end
            E_LOAD: begin
                a_we    = r_cok;
                a_waddr = r_ci;
                a_wdata = ld_a;
                b_we    = r_hp;
                b_waddr = r_pi;
                b_wdata = (r_b_rdata == 2'd3) ? r_b_rdata : r_b_rdata + 2'd1;
            end
            E_SCAN: begin
                a_re    = (r_k != K_END);
                a_raddr = CW'(r_k);
                b_re    = a_re;
                b_raddr = CW'(r_k);
                q_we    = scan_push;
                q_waddr = CW'(r_tail);
                q_wdata = r_pk;
            end
            E_QRD: begin
                q_re    = (r_head != r_tail);
                q_raddr = CW'(r_head);
            end
            E_ARD: begin
                a_re    = 1'b1;
                a_raddr = r_q_rdata;
            end
            E_BRD: begin
                b_re    = (r_s < r_scnt);
                b_raddr = (r_s == 2'd0) ? r_slot0 : r_slot1;
            end
            E_BWB: begin
                b_we    = (r_b_rdata != 2'd0);
                b_waddr = r_nb;
                b_wdata = r_b_rdata - 2'd1;
                q_we    = (r_b_rdata == 2'd1) && (r_tail != K_END);
                q_waddr = CW'(r_tail);
                q_wdata = r_nb;
            end
            E_RES: begin
                o_status.res_valid  = i_res_free;
                o_status.res_reason = res_reason;
            end
            E_CLEAR: begin
                a_we    = 1'b1;
                a_waddr = CW'(r_k);
                b_we    = 1'b1;
                b_waddr = CW'(r_k);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (a_we) r_a_mem[a_waddr] <= a_wdata;
        if (a_re) r_a_rdata <= r_a_mem[a_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (b_we) r_b_mem[b_waddr] <= b_wdata;
        if (b_re) r_b_rdata <= r_b_mem[b_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) r_q_mem[q_waddr] <= q_wdata;
        if (q_re) r_q_rdata <= r_q_mem[q_raddr];
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= E_CLEAR;
            r_k         <= '0;
            r_pv        <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
            r_visited   <= '0;
            r_fail      <= 1'b0;
            r_prev      <= '0;
            r_stack_cnt <= '0;
            r_over      <= 1'b0;
            r_bad       <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                E_IDLE: begin
                    if (i_item_valid) begin
                        r_prev      <= acc_cok ? i_color : 11'd0;
                        r_stack_cnt <= acc_cnt;
                        r_over      <= r_over | acc_over;
                        r_bad       <= r_bad | !acc_cok;
                        r_ci        <= acc_ci;
                        r_pi        <= acc_pi;
                        r_cok       <= acc_cok;
                        r_hp        <= acc_cok && (acc_prev != 11'd0);
                        r_sidx      <= SW'(acc_cnt - 1'b1);
                        r_last      <= i_last;
                    end
                end
                E_LOAD: begin
                    if (r_last) begin
                        r_k       <= '0;
                        r_pv      <= 1'b0;
                        r_head    <= '0;
                        r_tail    <= '0;
                        r_visited <= '0;
                        r_fail    <= 1'b0;
                    end
                end
                E_SCAN: begin
                    r_pv <= (r_k != K_END);
                    r_pk <= CW'(r_k);
                    if (r_k != K_END) r_k <= r_k + 1'b1;
                    // keep only the lowest failing color
                    if (r_pv && scan_bad && !r_fail) begin
                        r_fail        <= 1'b1;
                        r_fail_reason <= scan_reason;
                    end
                    if (scan_push) r_tail <= r_tail + 1'b1;
                end
                E_QRD: begin
                    if (r_head != r_tail) r_head <= r_head + 1'b1;
                end
                E_ARD: begin
                    r_visited <= r_visited + 1'b1;
                end
                E_SLOT: begin
                    r_scnt  <= r_a_rdata.scnt;
                    r_slot0 <= r_a_rdata.slot0;
                    r_slot1 <= r_a_rdata.slot1;
                    r_s     <= 2'd0;
                end
                E_BRD: begin
                    r_nb <= (r_s == 2'd0) ? r_slot0 : r_slot1;
                end
                E_BWB: begin
                    r_s <= r_s + 2'd1;
                    if (q_we) r_tail <= r_tail + 1'b1;
                end
                E_RES: begin
                    if (i_res_free) begin
                        r_k         <= '0;
                        r_prev      <= '0;
                        r_stack_cnt <= '0;
                        r_over      <= 1'b0;
                        r_bad       <= 1'b0;
                    end
                end
                E_CLEAR: begin
                    r_k <= r_k + 1'b1;
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTH
    a_head_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_tail) else $error("queue head passed tail");
    a_visit_le_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_visited <= r_tail) else $error("more colors visited than queued");
    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == E_IDLE && i_item_valid) |=> (r_state == E_LOAD))
        else $error("accepted item not written back");
    a_res_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.res_valid |=> (r_state == E_CLEAR && r_k == '0))
        else $error("result not followed by clearing sweep");
`endif

endmodule

@@ rtl/paired_stack_dependency_check_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paired_stack_dependency_check_core
// Loads stacks of colored items and checks that every color pairs up and
// that the stack dependency graph has no cycle.
//
//  channel   | dir | handshake    | payload
//  i_item    | in  | valid/ready  | color[10:0], new_stack, last
//  o_result  | out | valid/ready  | can_clear, fail_reason[2:0]
//  i_cfg_*   | in  | write enable | num_colors[10:0]
//
// Each item takes one read and one write-back of the color tables.
// The last item adds a scan over all MAX_COLORS table entries, then a queue
// walk over each visited color and its successor edges.
// After each result, and after reset, a sweep over all MAX_COLORS entries
// clears the tables; no item is taken during it.
// The result waits in an output register; the next sweep starts once it is
// held there, and a new result stalls until that register is free.
// ----------------------------------------------------------------------------
module paired_stack_dependency_check_core #(
    parameter int MAX_COLORS = 1024,
    parameter int MAX_STACKS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [10:0]         i_cfg_wr_data,
    pscd_item_if.sink           i_item,
    pscd_result_if.source       o_result
);
    import pscd_pkg::*;

    logic [CFG_W-1:0]    r_num_colors;
    logic                r_out_valid;
    logic                r_can_clear;
    logic [REASON_W-1:0] r_fail_reason;
    t_eng_status         eng_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_colors <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            r_num_colors <= i_cfg_wr_data;
        end
    end

    pscd_engine #(
        .MAX_COLORS (MAX_COLORS),
        .MAX_STACKS (MAX_STACKS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .i_color      (i_item.color),
        .i_new_stack  (i_item.new_stack),
        .i_last       (i_item.last),
        .i_num_colors (r_num_colors),
        .i_res_free   (!r_out_valid),
        .o_status     (eng_status)
    );

    assign i_item.ready = eng_status.ready;

    // hold the result until the sink takes the transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eng_status.res_valid) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eng_status.res_valid) begin
            r_can_clear   <= (eng_status.res_reason == FAIL_NONE);
            r_fail_reason <= eng_status.res_reason;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.can_clear   = r_can_clear;
    assign o_result.fail_reason = r_fail_reason;

endmodule
